[rtl/epp_pkg.sv]
// Shared types, widths, constants and arithmetic helpers for the perspective projector.
package epp_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int XY_W   = 33;              // CORDIC x/y, Q1.30 with headroom
	localparam int Z_W    = 34;              // CORDIC residual angle
	localparam int AX_W   = 20;              // Q16 trig terms and axis components
	localparam int D_W    = 33;              // point - camera, Q.8
	localparam int PROD_W = D_W + AX_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam int T_W    = SUM_W - 16;      // axis distance, Q.8
	localparam int CX_W   = 21;              // centre in Q.8
	localparam int TR_W   = 32;              // half-angle sine/cosine, unsigned
	localparam int NUM_W  = CX_W + TR_W + 1; // focal numerator, also focal width
	localparam int FH_W   = NUM_W / 2;
	localparam int PP_W   = T_W + FH_W;
	localparam int P_W    = T_W + NUM_W;
	localparam int Q_W    = 41;              // projected offset, capped at 2^40
	localparam int SX_W   = Q_W + 2;
	localparam int OUT_W  = 24;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic [Q_W-1:0] OFFSET_CAP = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [SX_W-1:0] OUT_MAX = SX_W'(8388607);
	localparam logic signed [SX_W-1:0] OUT_MIN = -SX_W'(8388608);
	localparam logic [13:0] WIDTH_RESET  = 14'd1920;
	localparam logic [13:0] HEIGHT_RESET = 14'd1080;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
		logic [Z_W-1:0]  z;
		logic            neg;
	} cord_t;

	typedef struct packed {
		logic [TR_W-1:0]  rem;
		logic [NUM_W-1:0] quo;
		logic [TR_W-1:0]  den;
		logic [T_W-1:0]   tx;
		logic [T_W-1:0]   ty;
		logic [T_W-1:0]   tz;
	} fdiv_t;

	typedef struct packed {
		logic           big;
		logic [T_W-1:0] rem;
		logic [Q_W-1:0] quo;
	} pdiv_t;

	typedef struct packed {
		pdiv_t          px;
		pdiv_t          py;
		logic [T_W-1:0] dep;
		logic           negx;
		logic           negy;
	} proj_t;

	function automatic logic signed [Z_W-1:0] atan_val(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = Z_W'(536870912);
			1: r = Z_W'(316933406);
			2: r = Z_W'(167458907);
			3: r = Z_W'(85004756);
			4: r = Z_W'(42667331);
			5: r = Z_W'(21354465);
			6: r = Z_W'(10679838);
			7: r = Z_W'(5340245);
			8: r = Z_W'(2670163);
			9: r = Z_W'(1335087);
			10: r = Z_W'(667544);
			11: r = Z_W'(333772);
			12: r = Z_W'(166886);
			13: r = Z_W'(83443);
			14: r = Z_W'(41722);
			15: r = Z_W'(20861);
			16: r = Z_W'(10430);
			17: r = Z_W'(5215);
			18: r = Z_W'(2608);
			19: r = Z_W'(1304);
			default: r = '0;
		endcase
		return r;
	endfunction

	// second and third quadrants are turned by half a turn, result negated later
	function automatic cord_t cord_init(input logic [31:0] theta);
		cord_t r;
		logic [31:0] th;
		r.neg = theta[31] ^ theta[30];
		th = {theta[31] ^ r.neg, theta[30:0]};
		r.x = CORDIC_GAIN;
		r.y = '0;
		r.z = {{(Z_W-32){th[31]}}, th};
		return r;
	endfunction

	function automatic cord_t cord_step(input cord_t a, input int i);
		cord_t r;
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		dx = $signed(a.y) >>> i;
		dy = $signed(a.x) >>> i;
		r.neg = a.neg;
		if (!a.z[Z_W-1]) begin
			r.x = $signed(a.x) - dx;
			r.y = $signed(a.y) + dy;
			r.z = $signed(a.z) - atan_val(i);
		end else begin
			r.x = $signed(a.x) + dx;
			r.y = $signed(a.y) - dy;
			r.z = $signed(a.z) + atan_val(i);
		end
		return r;
	endfunction

	function automatic logic signed [AX_W-1:0] to_q16(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] s;
		s = v + XY_W'(8192);
		return AX_W'(s >>> 14);
	endfunction

	function automatic logic signed [AX_W-1:0] mulq(input logic signed [AX_W-1:0] a,
			input logic signed [AX_W-1:0] b);
		logic signed [2*AX_W-1:0] p;
		p = a * b;
		p = p + (2*AX_W)'(32768);
		return AX_W'(p >>> 16);
	endfunction

	function automatic fdiv_t fdiv_step(input fdiv_t a);
		fdiv_t r;
		logic [TR_W:0] t;
		logic ge;
		r = a;
		t = {a.rem, a.quo[NUM_W-1]};
		ge = t >= {1'b0, a.den};
		r.rem = ge ? TR_W'(t - {1'b0, a.den}) : t[TR_W-1:0];
		r.quo = {a.quo[NUM_W-2:0], ge};
		return r;
	endfunction

	function automatic pdiv_t pdiv_step(input pdiv_t a, input logic [T_W-1:0] dep);
		pdiv_t r;
		logic [T_W:0] t;
		logic ge;
		r.big = a.big;
		t = {a.rem, a.quo[Q_W-1]};
		ge = t >= {1'b0, dep};
		r.rem = ge ? T_W'(t - {1'b0, dep}) : t[T_W-1:0];
		r.quo = {a.quo[Q_W-2:0], ge};
		return r;
	endfunction

	function automatic pdiv_t pdiv_init(input logic [P_W-1:0] p, input logic [T_W-1:0] dep);
		pdiv_t r;
		r.big = p[P_W-1:Q_W] >= (P_W-Q_W)'(dep);
		r.rem = p[Q_W+T_W-1:Q_W];
		r.quo = p[Q_W-1:0];
		return r;
	endfunction

	// half up rounding of the quotient, capped offset when it ran over
	function automatic logic [Q_W-1:0] pdiv_round(input pdiv_t a, input logic [T_W-1:0] dep);
		logic rnd;
		rnd = {a.rem, 1'b0} >= {1'b0, dep};
		if (a.big || a.quo[Q_W-1])
			return OFFSET_CAP;
		return a.quo + Q_W'(rnd);
	endfunction

endpackage

[rtl/euler_perspective_projection.sv]
// Pipelined world-to-screen perspective projector with pitch/yaw/roll camera.
//
// Usage: drive the point, camera position, angles and field of view with
// start high; the transaction is taken at any edge where start is high and
// busy is low. busy is never raised, so one transaction may enter every cycle.
// Each transaction yields exactly one result: done is high for one cycle with
// screen_x, screen_y (Q15.8) and saturated on the ports; the receiver must
// take it then, as results cannot be held back.
// The pipeline holds the 20-step CORDIC chain, the 54-stage bit-per-stage focal
// divider and the 41-stage projection divider. Throughput is one per cycle.
// screen_width / screen_height are written through cfg_valid / cfg_ready
// (ready always high) with cfg_index choosing the register; write them only
// while no transaction is in flight.
// Reset clears all valid bits and loads 1920 x 1080; payload stages are not
// cleared and no output strobe is raised until new transactions arrive.
module euler_perspective_projection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] camera_x,
	input  logic [31:0] camera_y,
	input  logic [31:0] camera_z,
	input  logic [15:0] pitch_angle,
	input  logic [15:0] yaw_angle,
	input  logic [15:0] roll_angle,
	input  logic [14:0] view_angle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data,
	output logic        done,
	output logic signed [23:0] screen_x,
	output logic signed [23:0] screen_y,
	output logic        saturated
);

	localparam int CS  = epp_pkg::CORDIC_STEPS;
	localparam int NF  = epp_pkg::NUM_W;
	localparam int NQ  = epp_pkg::Q_W;
	localparam int AXW = epp_pkg::AX_W;
	localparam int TW  = epp_pkg::T_W;
	localparam int LATENCY = 1 + CS + 4 + 1 + NF + 3 + 1 + NQ + 2;

	logic [13:0] width_q;
	logic [13:0] height_q;
	logic [epp_pkg::CX_W-1:0] cx;
	logic [epp_pkg::CX_W-1:0] cy;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cx = {width_q, 7'b0};
	assign cy = {height_q, 7'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= epp_pkg::WIDTH_RESET;
			height_q <= epp_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (epp_pkg::cfg_reg_t'(cfg_index))
				epp_pkg::REG_SCREEN_WIDTH: width_q <= cfg_data;
				epp_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- CORDIC: pitch, yaw, roll, half view angle
	epp_pkg::cord_t cord_s [CS+1][4];
	logic signed [epp_pkg::D_W-1:0] dif_s [CS+1][3];
	logic cvld_s [CS+1];
	logic [14:0] view_eff;

	assign view_eff = (view_angle == 15'd0) ? 15'd1 : view_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cvld_s[0] <= 1'b0;
		else
			cvld_s[0] <= start && !busy;
	end

	always_ff @(posedge clk) begin
		cord_s[0][0] <= epp_pkg::cord_init({pitch_angle, 16'b0});
		cord_s[0][1] <= epp_pkg::cord_init({yaw_angle, 16'b0});
		cord_s[0][2] <= epp_pkg::cord_init({roll_angle, 16'b0});
		cord_s[0][3] <= epp_pkg::cord_init({2'b0, view_eff, 15'b0});
		dif_s[0][0] <= $signed({point_x[31], point_x}) - $signed({camera_x[31], camera_x});
		dif_s[0][1] <= $signed({point_y[31], point_y}) - $signed({camera_y[31], camera_y});
		dif_s[0][2] <= $signed({point_z[31], point_z}) - $signed({camera_z[31], camera_z});
	end

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cvld_s[g+1] <= 1'b0;
			else
				cvld_s[g+1] <= cvld_s[g];
		end
		always_ff @(posedge clk) begin
			for (int k = 0; k < 4; k++)
				cord_s[g+1][k] <= epp_pkg::cord_step(cord_s[g][k], g);
			for (int k = 0; k < 3; k++)
				dif_s[g+1][k] <= dif_s[g][k];
		end
	end

	logic signed [epp_pkg::XY_W-1:0] sin_w [4];
	logic signed [epp_pkg::XY_W-1:0] cos_w [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sin_w[k] = cord_s[CS][k].neg ? -$signed(cord_s[CS][k].y) : $signed(cord_s[CS][k].y);
			cos_w[k] = cord_s[CS][k].neg ? -$signed(cord_s[CS][k].x) : $signed(cord_s[CS][k].x);
		end
	end

	// ---------------- axis construction and dot products
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [AXW-1:0] sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	logic [epp_pkg::TR_W-1:0] vs_s1, vc_s1;
	logic signed [epp_pkg::D_W-1:0] dif_s1 [3];
	logic signed [epp_pkg::D_W-1:0] dif_s2 [3];
	logic signed [epp_pkg::D_W-1:0] dif_s3 [3];
	logic signed [AXW-1:0] spcy_s2, spsy_s2, crsy_s2, crcy_s2, srcp_s2;
	logic signed [AXW-1:0] srsy_s2, cysr_s2, crcp_s2, sr_s2, cr_s2;
	logic signed [AXW-1:0] fwd_s2 [3];
	logic signed [AXW-1:0] axis_s3 [3][3];
	logic signed [epp_pkg::PROD_W-1:0] prod_s4 [3][3];
	logic [NF-1:0] num_s2, num_s3, num_s4;
	logic [epp_pkg::TR_W-1:0] den_s2, den_s3, den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cvld_s[CS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sp_s1 <= epp_pkg::to_q16(sin_w[0]);
		cp_s1 <= epp_pkg::to_q16(cos_w[0]);
		sy_s1 <= epp_pkg::to_q16(sin_w[1]);
		cy_s1 <= epp_pkg::to_q16(cos_w[1]);
		sr_s1 <= epp_pkg::to_q16(sin_w[2]);
		cr_s1 <= epp_pkg::to_q16(cos_w[2]);
		// degenerate half-angle: non-positive sine as 1, negative cosine as 0
		vs_s1 <= (sin_w[3] <= 0) ? epp_pkg::TR_W'(1) : sin_w[3][epp_pkg::TR_W-1:0];
		vc_s1 <= cos_w[3][epp_pkg::XY_W-1] ? '0 : cos_w[3][epp_pkg::TR_W-1:0];
		dif_s1 <= dif_s[CS];

		spcy_s2 <= epp_pkg::mulq(sp_s1, cy_s1);
		spsy_s2 <= epp_pkg::mulq(sp_s1, sy_s1);
		fwd_s2[0] <= epp_pkg::mulq(cp_s1, cy_s1);
		fwd_s2[1] <= epp_pkg::mulq(cp_s1, sy_s1);
		fwd_s2[2] <= sp_s1;
		crsy_s2 <= epp_pkg::mulq(cr_s1, sy_s1);
		crcy_s2 <= epp_pkg::mulq(cr_s1, cy_s1);
		srcp_s2 <= epp_pkg::mulq(sr_s1, cp_s1);
		srsy_s2 <= epp_pkg::mulq(sr_s1, sy_s1);
		cysr_s2 <= epp_pkg::mulq(cy_s1, sr_s1);
		crcp_s2 <= epp_pkg::mulq(cr_s1, cp_s1);
		sr_s2 <= sr_s1;
		cr_s2 <= cr_s1;
		num_s2 <= NF'(cx) * NF'(vc_s1) + NF'(vs_s1[epp_pkg::TR_W-1:1]);
		den_s2 <= vs_s1;
		dif_s2 <= dif_s1;

		// axis rows: right, up, forward
		axis_s3[0][0] <= epp_pkg::mulq(sr_s2, spcy_s2) - crsy_s2;
		axis_s3[0][1] <= epp_pkg::mulq(sr_s2, spsy_s2) + crcy_s2;
		axis_s3[0][2] <= -srcp_s2;
		axis_s3[1][0] <= -(epp_pkg::mulq(cr_s2, spcy_s2) + srsy_s2);
		axis_s3[1][1] <= cysr_s2 - epp_pkg::mulq(cr_s2, spsy_s2);
		axis_s3[1][2] <= crcp_s2;
		axis_s3[2] <= fwd_s2;
		num_s3 <= num_s2;
		den_s3 <= den_s2;
		dif_s3 <= dif_s2;

		for (int a = 0; a < 3; a++)
			for (int k = 0; k < 3; k++)
				prod_s4[a][k] <= dif_s3[k] * axis_s3[a][k];
		num_s4 <= num_s3;
		den_s4 <= den_s3;
	end

	logic signed [epp_pkg::SUM_W-1:0] dsum [3];
	logic signed [TW-1:0] tdist [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dsum[a] = epp_pkg::SUM_W'(prod_s4[a][0]) + epp_pkg::SUM_W'(prod_s4[a][1])
				+ epp_pkg::SUM_W'(prod_s4[a][2]) + epp_pkg::SUM_W'(32768);
			tdist[a] = dsum[a][epp_pkg::SUM_W-1:16];
		end
	end

	// ---------------- focal scale divider, one quotient bit per stage
	epp_pkg::fdiv_t fd_s [NF+1];
	logic fvld_s [NF+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fvld_s[0] <= 1'b0;
		else
			fvld_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		fd_s[0].rem <= '0;
		fd_s[0].quo <= num_s4;
		fd_s[0].den <= den_s4;
		fd_s[0].tx  <= tdist[0];
		fd_s[0].ty  <= tdist[1];
		// depth clamped to one unit
		fd_s[0].tz  <= (tdist[2] < TW'(256)) ? TW'(256) : tdist[2];
	end

	for (genvar g = 0; g < NF; g++) begin : g_fdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				fvld_s[g+1] <= 1'b0;
			else
				fvld_s[g+1] <= fvld_s[g];
		end
		always_ff @(posedge clk)
			fd_s[g+1] <= epp_pkg::fdiv_step(fd_s[g]);
	end

	// ---------------- |t| * f, split into two partial products
	logic v_s6, v_s7, v_s8;
	logic [TW-1:0] magx_s6, magy_s6, dep_s6, dep_s7, dep_s8;
	logic negx_s6, negy_s6, negx_s7, negy_s7, negx_s8, negy_s8;
	logic [NF-1:0] f_s6;
	logic [epp_pkg::PP_W-1:0] pxl_s7, pxh_s7, pyl_s7, pyh_s7;
	logic [epp_pkg::P_W-1:0] px_s8, py_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s6 <= fvld_s[NF];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		negx_s6 <= fd_s[NF].tx[TW-1];
		negy_s6 <= fd_s[NF].ty[TW-1];
		magx_s6 <= fd_s[NF].tx[TW-1] ? -fd_s[NF].tx : fd_s[NF].tx;
		magy_s6 <= fd_s[NF].ty[TW-1] ? -fd_s[NF].ty : fd_s[NF].ty;
		f_s6    <= fd_s[NF].quo;
		dep_s6  <= fd_s[NF].tz;

		pxl_s7 <= epp_pkg::PP_W'(magx_s6) * epp_pkg::PP_W'(f_s6[epp_pkg::FH_W-1:0]);
		pxh_s7 <= epp_pkg::PP_W'(magx_s6) * epp_pkg::PP_W'(f_s6[NF-1:epp_pkg::FH_W]);
		pyl_s7 <= epp_pkg::PP_W'(magy_s6) * epp_pkg::PP_W'(f_s6[epp_pkg::FH_W-1:0]);
		pyh_s7 <= epp_pkg::PP_W'(magy_s6) * epp_pkg::PP_W'(f_s6[NF-1:epp_pkg::FH_W]);
		negx_s7 <= negx_s6;
		negy_s7 <= negy_s6;
		dep_s7  <= dep_s6;

		px_s8 <= epp_pkg::P_W'(pxl_s7) + (epp_pkg::P_W'(pxh_s7) << epp_pkg::FH_W);
		py_s8 <= epp_pkg::P_W'(pyl_s7) + (epp_pkg::P_W'(pyh_s7) << epp_pkg::FH_W);
		negx_s8 <= negx_s7;
		negy_s8 <= negy_s7;
		dep_s8  <= dep_s7;
	end

	// ---------------- projection dividers, x and y side by side
	epp_pkg::proj_t pd_s [NQ+1];
	logic pvld_s [NQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pvld_s[0] <= 1'b0;
		else
			pvld_s[0] <= v_s8;
	end

	always_ff @(posedge clk) begin
		pd_s[0].px   <= epp_pkg::pdiv_init(px_s8, dep_s8);
		pd_s[0].py   <= epp_pkg::pdiv_init(py_s8, dep_s8);
		pd_s[0].dep  <= dep_s8;
		pd_s[0].negx <= negx_s8;
		pd_s[0].negy <= negy_s8;
	end

	for (genvar g = 0; g < NQ; g++) begin : g_pdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pvld_s[g+1] <= 1'b0;
			else
				pvld_s[g+1] <= pvld_s[g];
		end
		always_ff @(posedge clk) begin
			pd_s[g+1].px   <= epp_pkg::pdiv_step(pd_s[g].px, pd_s[g].dep);
			pd_s[g+1].py   <= epp_pkg::pdiv_step(pd_s[g].py, pd_s[g].dep);
			pd_s[g+1].dep  <= pd_s[g].dep;
			pd_s[g+1].negx <= pd_s[g].negx;
			pd_s[g+1].negy <= pd_s[g].negy;
		end
	end

	// ---------------- rounding, centre offset and saturation
	logic v_s10;
	logic [NQ-1:0] resx_s10, resy_s10;
	logic negx_s10, negy_s10;
	logic signed [epp_pkg::SX_W-1:0] offx, offy, sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s10 <= pvld_s[NQ];
			done  <= v_s10;
		end
	end

	always_comb begin
		offx = negx_s10 ? -epp_pkg::SX_W'(resx_s10) : epp_pkg::SX_W'(resx_s10);
		offy = negy_s10 ? -epp_pkg::SX_W'(resy_s10) : epp_pkg::SX_W'(resy_s10);
		sx = epp_pkg::SX_W'(cx) + offx;
		sy = epp_pkg::SX_W'(cy) - offy;
	end

	always_ff @(posedge clk) begin
		resx_s10 <= epp_pkg::pdiv_round(pd_s[NQ].px, pd_s[NQ].dep);
		resy_s10 <= epp_pkg::pdiv_round(pd_s[NQ].py, pd_s[NQ].dep);
		negx_s10 <= pd_s[NQ].negx;
		negy_s10 <= pd_s[NQ].negy;

		if (sx > epp_pkg::OUT_MAX)
			screen_x <= epp_pkg::OUT_W'(epp_pkg::OUT_MAX);
		else if (sx < epp_pkg::OUT_MIN)
			screen_x <= epp_pkg::OUT_W'(epp_pkg::OUT_MIN);
		else
			screen_x <= sx[epp_pkg::OUT_W-1:0];
		if (sy > epp_pkg::OUT_MAX)
			screen_y <= epp_pkg::OUT_W'(epp_pkg::OUT_MAX);
		else if (sy < epp_pkg::OUT_MIN)
			screen_y <= epp_pkg::OUT_W'(epp_pkg::OUT_MIN);
		else
			screen_y <= sy[epp_pkg::OUT_W-1:0];
		saturated <= (sx > epp_pkg::OUT_MAX) || (sx < epp_pkg::OUT_MIN)
			|| (sy > epp_pkg::OUT_MAX) || (sy < epp_pkg::OUT_MIN);
	end

	// ---------------- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transaction did not come out after the pipeline latency");

	a_depth_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		fvld_s[0] |=> (!fd_s[0].tz[TW-1] && fd_s[0].tz >= TW'(256)) || !fvld_s[0])
		else $error("depth below one unit entered the divider");

	a_focal_rem: assert property (@(posedge clk) disable iff (!arst_n)
		fvld_s[NF] |-> fd_s[NF].rem < fd_s[NF].den)
		else $error("focal divider remainder not below divisor");

	a_offset_cap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> (resx_s10 <= epp_pkg::OFFSET_CAP && resy_s10 <= epp_pkg::OFFSET_CAP))
		else $error("projected offset above its cap");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (screen_x == 24'sh7FFFFF || screen_x == -24'sh800000
			|| screen_y == 24'sh7FFFFF || screen_y == -24'sh800000))
		else $error("saturated flag without a clipped coordinate");

endmodule
